### rtl/core/enclave_measurement_hasher_defines.svh
// ----------------------------------------------------------------------------
// enclave_measurement_hasher_defines
// Assertion macros used by the measurement hasher.
// ----------------------------------------------------------------------------
`ifndef ENCLAVE_MEASUREMENT_HASHER_DEFINES_SVH
`define ENCLAVE_MEASUREMENT_HASHER_DEFINES_SVH
// Implication checked at every rising clock edge outside reset.
`define EMH_ASSERT_IMP(lbl, clk, rst_n, pre, post) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
	else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define EMH_ASSERT_NEXT(lbl, clk, rst_n, pre, post) \
lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
	else $error("assertion failed");
`endif

### rtl/core/emh_pkg.sv
// ----------------------------------------------------------------------------
// emh_pkg
// Types, constants and SHA-256 helper functions for the measurement hasher.
// ----------------------------------------------------------------------------
package emh_pkg;
	localparam int PAGE_BYTES = 4096;
	localparam int CHUNK_BYTES = 256;
	localparam int PAGE_WORDS = PAGE_BYTES / 8;
	localparam int CHUNK_WORDS = CHUNK_BYTES / 8;
	localparam int WL_W = $clog2(PAGE_WORDS + 1);

	localparam logic [1:0] FUNC_CREATE = 2'd0;
	localparam logic [1:0] FUNC_ADD = 2'd1;
	localparam logic [1:0] FUNC_DATA = 2'd2;
	localparam logic [1:0] FUNC_FINAL = 2'd3;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_INVALID = 2'd1;
	localparam logic [1:0] ST_SEQ = 2'd2;

	// Record tags, byte 0 in bits 63:56 (big-endian word order of the block).
	localparam logic [63:0] TAG_CREATE = 64'h4543524541544500;
	localparam logic [63:0] TAG_ADD = 64'h4541444400000000;
	localparam logic [63:0] TAG_EXTEND = 64'h45455854454e4400;

	typedef struct packed {
		logic [1:0] func;
		logic [63:0] base;
		logic [63:0] addr;
		logic [63:0] page_flags;
		logic extend;
		logic [31:0] ssa_frame_size;
		logic [63:0] enclave_size;
		logic [63:0] page_word;
	} in_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic digest_valid;
		logic [63:0] digest_0;
		logic [63:0] digest_1;
		logic [63:0] digest_2;
		logic [63:0] digest_3;
	} out_word_t;

	// Control between the sequencer and the compression core.
	typedef struct packed {
		logic start;
		logic restart;
	} core_ctl_t;

	typedef struct packed {
		logic busy;
	} core_sts_t;

	function automatic logic [63:0] bswap64(input logic [63:0] x);
		logic [63:0] r;
		for (int i = 0; i < 8; i++) r[8*i +: 8] = x[56-8*i +: 8];
		return r;
	endfunction

	function automatic logic [31:0] rk(input logic [5:0] i);
		logic [31:0] t [64];
		t = '{32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b,
			32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01,
			32'h243185be, 32'h550c7dc3, 32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7,
			32'hc19bf174, 32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
			32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da, 32'h983e5152,
			32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
			32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc,
			32'h53380d13, 32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
			32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3, 32'hd192e819,
			32'hd6990624, 32'hf40e3585, 32'h106aa070, 32'h19a4c116, 32'h1e376c08,
			32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f,
			32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
			32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
		return t[i];
	endfunction

	function automatic logic [31:0] init_h(input logic [2:0] i);
		logic [31:0] t [8];
		t = '{32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
			32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};
		return t[i];
	endfunction
endpackage

### rtl/core/emh_core.sv
// ----------------------------------------------------------------------------
// emh_core
// SHA-256 compression: one round per cycle over a 16-word message schedule.
// ----------------------------------------------------------------------------
module emh_core (
	input logic clk,
	input logic arst_n,
	input emh_pkg::core_ctl_t ctl,
	input logic [511:0] block,
	output emh_pkg::core_sts_t sts,
	output logic [255:0] hash
);
	logic [31:0] h_q [8];
	logic [31:0] v_q [8];
	logic [31:0] w_q [16];
	logic [5:0] round_q;
	logic busy_q;
	logic [31:0] a, e, t1, t2, s0, s1, wn;

	// Round and schedule arithmetic.
	always_comb begin
		a = v_q[0];
		e = v_q[4];
		t1 = v_q[7] + ({e[5:0], e[31:6]} ^ {e[10:0], e[31:11]} ^ {e[24:0], e[31:25]})
			+ ((e & v_q[5]) ^ (~e & v_q[6])) + emh_pkg::rk(round_q) + w_q[0];
		t2 = ({a[1:0], a[31:2]} ^ {a[12:0], a[31:13]} ^ {a[21:0], a[31:22]})
			+ ((a & v_q[1]) ^ (a & v_q[2]) ^ (v_q[1] & v_q[2]));
		s0 = {w_q[1][6:0], w_q[1][31:7]} ^ {w_q[1][17:0], w_q[1][31:18]} ^ (w_q[1] >> 3);
		s1 = {w_q[14][16:0], w_q[14][31:17]} ^ {w_q[14][18:0], w_q[14][31:19]}
			^ (w_q[14] >> 10);
		wn = w_q[0] + s0 + w_q[9] + s1;
	end

	// Round sequencing; the hash words fold in after the last round.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			round_q <= '0;
			for (int i = 0; i < 8; i++) h_q[i] <= emh_pkg::init_h(3'(i));
		end else if (ctl.restart) begin
			for (int i = 0; i < 8; i++) h_q[i] <= emh_pkg::init_h(3'(i));
		end else if (ctl.start) begin
			busy_q <= 1'b1;
			round_q <= '0;
		end else if (busy_q) begin
			round_q <= round_q + 6'd1;
			if (round_q == 6'd63) begin
				busy_q <= 1'b0;
				h_q[0] <= h_q[0] + t1 + t2;
				h_q[1] <= h_q[1] + v_q[0];
				h_q[2] <= h_q[2] + v_q[1];
				h_q[3] <= h_q[3] + v_q[2];
				h_q[4] <= h_q[4] + v_q[3] + t1;
				h_q[5] <= h_q[5] + v_q[4];
				h_q[6] <= h_q[6] + v_q[5];
				h_q[7] <= h_q[7] + v_q[6];
			end
		end
	end

	// Working variables and schedule window.
	always_ff @(posedge clk) begin
		if (ctl.start) begin
			for (int i = 0; i < 8; i++) v_q[i] <= h_q[i];
			for (int i = 0; i < 16; i++) w_q[i] <= block[511-32*i -: 32];
		end else if (busy_q) begin
			v_q[7] <= v_q[6]; v_q[6] <= v_q[5]; v_q[5] <= v_q[4];
			v_q[4] <= v_q[3] + t1;
			v_q[3] <= v_q[2]; v_q[2] <= v_q[1]; v_q[1] <= v_q[0];
			v_q[0] <= t1 + t2;
			for (int i = 0; i < 15; i++) w_q[i] <= w_q[i+1];
			w_q[15] <= wn;
		end
	end

	assign sts.busy = busy_q;
	always_comb begin
		for (int i = 0; i < 8; i++) hash[255-32*i -: 32] = h_q[i];
	end
endmodule

### rtl/core/enclave_measurement_hasher.sv
// ----------------------------------------------------------------------------
// enclave_measurement_hasher
// SHA-256 enclave measurement built from create, add, data and finalize words.
// ----------------------------------------------------------------------------
//  channel | dir | handshake            | payload
//  in      | in  | in_valid / in_ready  | in_data  (emh_pkg::in_word_t)
//  out     | out | out_valid / out_ready| out_data (emh_pkg::out_word_t)
// Every record is absorbed as 8-byte lanes, one lane per cycle while no
// compression is pending. A full 64-byte block passes through the shared
// round unit as a start, 64 rounds and a pick-up of the new hash. Between
// acceptances a create needs one compression, a data word none when it closes
// no block, a finalize one or two compressions, and a rejected word none.
// in_ready is low from acceptance until the result word is taken; a stall on
// out_ready stretches that time. Reset gives the SHA-256 initial hash and
// closes the measurement.
`include "enclave_measurement_hasher_defines.svh"
module enclave_measurement_hasher (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input emh_pkg::in_word_t in_data,
	output logic out_valid,
	input logic out_ready,
	output emh_pkg::out_word_t out_data
);
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_FEED = 3'd1;
	localparam logic [2:0] S_WAIT = 3'd2;
	localparam logic [2:0] S_OUT = 3'd3;

	logic [2:0] state_q;
	emh_pkg::in_word_t item_q;
	logic [63:0] blk_q [8];
	logic [2:0] lane_q;
	logic [3:0] step_q;
	logic [3:0] nsteps_q;
	logic [63:0] msg_bits_q;
	logic [63:0] len_q;
	logic [63:0] page_off_q;
	logic [emh_pkg::WL_W-1:0] words_left_q;
	logic open_q;
	logic final_q;
	logic start_q;
	emh_pkg::out_word_t res_q;
	emh_pkg::core_ctl_t ctl;
	emh_pkg::core_sts_t sts;
	logic [511:0] block;
	logic [255:0] hash;
	logic [63:0] lane_val;
	logic [63:0] off;
	logic [63:0] done_b;
	logic [63:0] ssa_sw;
	logic [63:0] esz_sw;
	logic chunk_hdr;

	emh_core u_core (.clk(clk), .arst_n(arst_n), .ctl(ctl), .block(block), .sts(sts),
		.hash(hash));

	always_comb begin
		for (int i = 0; i < 8; i++) block[511-64*i -: 64] = blk_q[i];
	end

	assign off = item_q.addr - item_q.base;
	assign done_b = 64'(emh_pkg::PAGE_WORDS - 32'(words_left_q)) << 3;
	assign chunk_hdr = (done_b[$clog2(emh_pkg::CHUNK_BYTES)-1:0] == '0);
	assign ssa_sw = emh_pkg::bswap64({32'd0, item_q.ssa_frame_size});
	assign esz_sw = emh_pkg::bswap64(item_q.enclave_size);

	// Lane value for the current step of the current word.
	always_comb begin
		lane_val = '0;
		if (final_q) begin
			if (step_q == 4'd0) lane_val = 64'h8000000000000000;
			else if (lane_q == 3'd7) lane_val = len_q;
		end else begin
			case (item_q.func)
				emh_pkg::FUNC_CREATE: begin
					if (step_q == 4'd0) lane_val = emh_pkg::TAG_CREATE;
					else if (step_q == 4'd1) lane_val = {ssa_sw[63:32], esz_sw[63:32]};
					else if (step_q == 4'd2) lane_val = {esz_sw[31:0], 32'd0};
				end
				emh_pkg::FUNC_ADD: begin
					if (step_q == 4'd0) lane_val = emh_pkg::TAG_ADD;
					else if (step_q == 4'd1) lane_val = emh_pkg::bswap64(off);
					else if (step_q == 4'd2) lane_val = emh_pkg::bswap64(item_q.page_flags);
				end
				emh_pkg::FUNC_DATA: begin
					if (step_q == nsteps_q - 4'd1) lane_val = emh_pkg::bswap64(item_q.page_word);
					else if (step_q == 4'd0) lane_val = emh_pkg::TAG_EXTEND;
					else if (step_q == 4'd1) lane_val = emh_pkg::bswap64(page_off_q + done_b);
				end
				default: lane_val = '0;
			endcase
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = (state_q == S_OUT);
	assign out_data = res_q;
	// The core start is raised in the cycle after lane 7 is written, so it sees the full block.
	assign ctl = '{start: start_q, restart: (state_q == S_IDLE) && in_valid
		&& (in_data.func == emh_pkg::FUNC_CREATE)};

	// Block buffer lanes.
	always_ff @(posedge clk) begin
		if (state_q == S_FEED) blk_q[lane_q] <= lane_val;
	end

	// Sequencer: accept, feed lanes, wait for compression, deliver.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			lane_q <= '0;
			step_q <= '0;
			nsteps_q <= '0;
			msg_bits_q <= '0;
			len_q <= '0;
			page_off_q <= '0;
			words_left_q <= '0;
			open_q <= 1'b0;
			final_q <= 1'b0;
			start_q <= 1'b0;
			res_q <= '0;
			item_q <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						item_q <= in_data;
						step_q <= '0;
						case (in_data.func)
							emh_pkg::FUNC_CREATE: begin
								state_q <= S_FEED;
								nsteps_q <= 4'd8;
								msg_bits_q <= '0;
								lane_q <= '0;
								words_left_q <= '0;
								page_off_q <= '0;
								open_q <= 1'b1;
							end
							emh_pkg::FUNC_ADD: begin
								nsteps_q <= 4'd8;
								if (!open_q || words_left_q != '0) begin
									res_q.status <= emh_pkg::ST_SEQ;
									state_q <= S_OUT;
								end else if (in_data.base == '0 || in_data.addr == '0 ||
									in_data.page_flags == '0 || in_data.addr < in_data.base) begin
									res_q.status <= emh_pkg::ST_INVALID;
									state_q <= S_OUT;
								end else begin
									state_q <= S_FEED;
									if (in_data.extend) begin
										page_off_q <= in_data.addr - in_data.base;
										words_left_q <= emh_pkg::WL_W'(emh_pkg::PAGE_WORDS);
									end
								end
							end
							emh_pkg::FUNC_DATA: begin
								if (words_left_q == '0) begin
									res_q.status <= emh_pkg::ST_SEQ;
									state_q <= S_OUT;
								end else begin
									state_q <= S_FEED;
								end
								// A data word that opens a chunk carries an EEXTEND record first.
								nsteps_q <= chunk_hdr ? 4'd9 : 4'd1;
							end
							default: begin
								if (!open_q || words_left_q != '0) begin
									res_q.status <= emh_pkg::ST_SEQ;
									state_q <= S_OUT;
								end else begin
									state_q <= S_FEED;
									final_q <= 1'b1;
									len_q <= msg_bits_q;
									open_q <= 1'b0;
									// Padding runs to lane 7 of the block holding the length.
									nsteps_q <= 4'd1 + ((lane_q == 3'd7) ? 4'd8 : 4'd0)
										+ {1'b0, 3'd7 - lane_q};
								end
							end
						endcase
					end
				end
				S_FEED: begin
					lane_q <= lane_q + 3'd1;
					msg_bits_q <= msg_bits_q + 64'd64;
					step_q <= step_q + 4'd1;
					if (lane_q == 3'd7) begin
						start_q <= 1'b1;
						state_q <= S_WAIT;
					end else if (step_q + 4'd1 == nsteps_q) begin
						state_q <= S_OUT;
					end
					if (step_q + 4'd1 == nsteps_q && item_q.func == emh_pkg::FUNC_DATA &&
						!final_q) begin
						words_left_q <= words_left_q - 1'b1;
					end
				end
				S_WAIT: begin
					start_q <= 1'b0;
					if (!sts.busy && !ctl.start) begin
						if (step_q == nsteps_q) begin
							state_q <= S_OUT;
							if (final_q) begin
								res_q.digest_valid <= 1'b1;
								res_q.digest_0 <= hash[255:192];
								res_q.digest_1 <= hash[191:128];
								res_q.digest_2 <= hash[127:64];
								res_q.digest_3 <= hash[63:0];
							end
						end else begin
							state_q <= S_FEED;
						end
					end
				end
				S_OUT: begin
					// The result clears once taken, so the next word starts from zero.
					if (out_ready) begin
						state_q <= S_IDLE;
						res_q <= '0;
						final_q <= 1'b0;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	`EMH_ASSERT_IMP(a_idle_no_core, clk, arst_n, state_q == S_IDLE, !sts.busy)
	`EMH_ASSERT_IMP(a_digest_final, clk, arst_n, out_valid && out_data.digest_valid,
		out_data.status == emh_pkg::ST_OK)
	`EMH_ASSERT_NEXT(a_start_busy, clk, arst_n, ctl.start, sts.busy)
endmodule

### tb/tb_top.sv
// ----------------------------------------------------------------------------
// Enclave measurement hasher testbench
// Drives create, add, data and finalize words with random bursts and output
// stalls, predicts status and SHA-256 digests, and checks every result word.
// ----------------------------------------------------------------------------

// Scoreboard: keeps its own measurement state and the queue of expected words.
class measurement_board;
	logic [31:0] h[8];
	logic [7:0] blk[64];
	logic [63:0] msg_bits;
	logic [63:0] pg_off;
	int words_left;
	bit is_open;
	emh_pkg::out_word_t pending[$];
	int errors;

	function new();
		errors = 0;
		words_left = 0;
		is_open = 0;
		pg_off = '0;
		restart();
	endfunction

	function void restart();
		for (int i = 0; i < 8; i++) h[i] = emh_pkg::init_h(3'(i));
		for (int i = 0; i < 64; i++) blk[i] = '0;
		msg_bits = '0;
	endfunction

	function logic [31:0] ror(logic [31:0] x, int n);
		return (x >> n) | (x << (32 - n));
	endfunction

	// One SHA-256 compression over the filled block.
	function void compress();
		logic [31:0] w[64];
		logic [31:0] v[8];
		logic [31:0] t1, t2, s0, s1;
		for (int i = 0; i < 16; i++)
			w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
		for (int i = 16; i < 64; i++) begin
			s0 = ror(w[i-15], 7) ^ ror(w[i-15], 18) ^ (w[i-15] >> 3);
			s1 = ror(w[i-2], 17) ^ ror(w[i-2], 19) ^ (w[i-2] >> 10);
			w[i] = w[i-16] + s0 + w[i-7] + s1;
		end
		for (int i = 0; i < 8; i++) v[i] = h[i];
		for (int r = 0; r < 64; r++) begin
			t1 = v[7] + (ror(v[4], 6) ^ ror(v[4], 11) ^ ror(v[4], 25))
				+ ((v[4] & v[5]) ^ (~v[4] & v[6])) + emh_pkg::rk(6'(r)) + w[r];
			t2 = (ror(v[0], 2) ^ ror(v[0], 13) ^ ror(v[0], 22))
				+ ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
			v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
			v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
		end
		for (int i = 0; i < 8; i++) h[i] += v[i];
	endfunction

	function void take_byte(logic [7:0] b);
		int idx;
		idx = int'(msg_bits[8:3]);
		blk[idx] = b;
		msg_bits += 64'd8;
		if (idx == 63) compress();
	endfunction

	// Tag constants hold byte 0 in bits 63:56.
	function void take_tag(logic [63:0] t);
		for (int i = 0; i < 8; i++) take_byte(t[63-8*i -: 8]);
	endfunction

	function void take_le(logic [63:0] x, int n);
		for (int i = 0; i < n; i++) take_byte(x[8*i +: 8]);
	endfunction

	function void take_zeros(int n);
		for (int i = 0; i < n; i++) take_byte(8'h00);
	endfunction

	// Note an accepted input word and queue the result it must produce.
	function void note_input(emh_pkg::in_word_t d);
		emh_pkg::out_word_t e;
		logic [63:0] off, done, len;
		e = '0;
		e.status = emh_pkg::ST_OK;
		case (d.func)
			emh_pkg::FUNC_CREATE: begin
				restart();
				words_left = 0;
				pg_off = '0;
				is_open = 1;
				take_tag(emh_pkg::TAG_CREATE);
				take_le({32'd0, d.ssa_frame_size}, 4);
				take_le(d.enclave_size, 8);
				take_zeros(44);
			end
			emh_pkg::FUNC_ADD: begin
				if (!is_open || words_left != 0) begin
					e.status = emh_pkg::ST_SEQ;
				end else if (d.base == 0 || d.addr == 0 || d.page_flags == 0
						|| d.addr < d.base) begin
					e.status = emh_pkg::ST_INVALID;
				end else begin
					off = d.addr - d.base;
					take_tag(emh_pkg::TAG_ADD);
					take_le(off, 8);
					take_le(d.page_flags, 8);
					take_zeros(40);
					if (d.extend) begin
						pg_off = off;
						words_left = emh_pkg::PAGE_WORDS;
					end
				end
			end
			emh_pkg::FUNC_DATA: begin
				if (words_left == 0) begin
					e.status = emh_pkg::ST_SEQ;
				end else begin
					done = 64'(emh_pkg::PAGE_WORDS - words_left) * 8;
					if (done % emh_pkg::CHUNK_BYTES == 0) begin
						take_tag(emh_pkg::TAG_EXTEND);
						take_le(pg_off + done, 8);
						take_zeros(48);
					end
					take_le(d.page_word, 8);
					words_left--;
				end
			end
			default: begin
				if (!is_open || words_left != 0) begin
					e.status = emh_pkg::ST_SEQ;
				end else begin
					len = msg_bits;
					take_byte(8'h80);
					while (msg_bits[8:3] != 6'd56) take_byte(8'h00);
					for (int i = 0; i < 8; i++) take_byte(len[63-8*i -: 8]);
					e.digest_valid = 1'b1;
					e.digest_0 = {h[0], h[1]};
					e.digest_1 = {h[2], h[3]};
					e.digest_2 = {h[4], h[5]};
					e.digest_3 = {h[6], h[7]};
					is_open = 0;
				end
			end
		endcase
		pending.push_back(e);
	endfunction

	task report(string what, logic [63:0] got, logic [63:0] want);
		errors++;
		$display("mismatch %s: got %h expected %h", what, got, want);
	endtask

	// Compare a result word with the oldest expectation.
	task check_result(emh_pkg::out_word_t r);
		emh_pkg::out_word_t e;
		if (pending.size() == 0) begin
			report("unexpected word", 64'(r.status), 64'd0);
			return;
		end
		e = pending.pop_front();
		if (r.status !== e.status) report("status", 64'(r.status), 64'(e.status));
		if (r.digest_valid !== e.digest_valid)
			report("digest_valid", 64'(r.digest_valid), 64'(e.digest_valid));
		if (r.digest_0 !== e.digest_0) report("digest_0", r.digest_0, e.digest_0);
		if (r.digest_1 !== e.digest_1) report("digest_1", r.digest_1, e.digest_1);
		if (r.digest_2 !== e.digest_2) report("digest_2", r.digest_2, e.digest_2);
		if (r.digest_3 !== e.digest_3) report("digest_3", r.digest_3, e.digest_3);
	endtask
endclass

module tb_top;
	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_ready;
	emh_pkg::in_word_t in_data;
	logic out_valid;
	logic out_ready;
	emh_pkg::out_word_t out_data;

	measurement_board board;
	int burst_left;
	int sent;
	bit stall_mode;

	enclave_measurement_hasher dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.out_data(out_data)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	function automatic logic [63:0] rand64();
		return {$urandom(), $urandom()};
	endfunction

	// Random field values leaning toward the extremes.
	function automatic logic [63:0] pick64();
		case ($urandom_range(0, 5))
			0: return '0;
			1: return '1;
			2: return 64'(1);
			default: return rand64();
		endcase
	endfunction

	// Send one word: random gap between bursts, then hold until accepted.
	task automatic send_word(emh_pkg::in_word_t d);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 12);
			gap = $urandom_range(0, 6);
			if (gap != 0) begin
				in_valid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		burst_left--;
		in_valid <= 1'b1;
		in_data <= d;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		board.note_input(d);
		sent++;
		@(negedge clk);
	endtask

	task automatic send_create(logic [31:0] ssa, logic [63:0] esize);
		emh_pkg::in_word_t d;
		d = '0;
		d.func = emh_pkg::FUNC_CREATE;
		d.ssa_frame_size = ssa;
		d.enclave_size = esize;
		d.base = rand64();
		d.page_word = rand64();
		send_word(d);
	endtask

	task automatic send_add(logic [63:0] b, logic [63:0] a, logic [63:0] f, logic x);
		emh_pkg::in_word_t d;
		d = '0;
		d.func = emh_pkg::FUNC_ADD;
		d.base = b;
		d.addr = a;
		d.page_flags = f;
		d.extend = x;
		d.ssa_frame_size = $urandom();
		send_word(d);
	endtask

	task automatic send_data(logic [63:0] w);
		emh_pkg::in_word_t d;
		d = '0;
		d.func = emh_pkg::FUNC_DATA;
		d.page_word = w;
		d.addr = rand64();
		send_word(d);
	endtask

	task automatic send_final();
		emh_pkg::in_word_t d;
		d = '0;
		d.func = emh_pkg::FUNC_FINAL;
		d.enclave_size = rand64();
		send_word(d);
	endtask

	task automatic send_page(bit use_ones);
		for (int i = 0; i < emh_pkg::PAGE_WORDS; i++) send_data(use_ones ? '1 : rand64());
	endtask

	// Receiver stalls: alternating stretches of always-ready and random stalls.
	always @(negedge clk) begin
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else begin
			if ($urandom_range(0, 63) == 0) stall_mode = ~stall_mode;
			out_ready <= stall_mode ? ($urandom_range(0, 2) != 0) : 1'b1;
		end
	end

	// Check each accepted result word.
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) board.check_result(out_data);
	end

	task automatic drain();
		in_valid <= 1'b0;
		while (board.pending.size() != 0) @(posedge clk);
		@(negedge clk);
	endtask

	initial begin
		logic [63:0] b;
		board = new();
		burst_left = 0;
		sent = 0;
		in_valid = 1'b0;
		in_data = '0;
		arst_n = 1'b0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Directed: sequencing errors before any create, then finalize, invalid-add and page-extend cases.
		send_add(64'h1000, 64'h2000, 64'h1, 1'b0);
		send_data('1);
		send_final();
		send_create('0, '0);
		send_final();
		send_final();
		send_create('1, '1);
		send_add(64'h0, 64'h2000, 64'h1, 1'b0);
		send_add(64'h1000, 64'h0, 64'h1, 1'b0);
		send_add(64'h1000, 64'h2000, 64'h0, 1'b0);
		send_add(64'h3000, 64'h2000, 64'h1, 1'b0);
		send_add('1, '1, '1, 1'b0);
		send_add(64'h1, '1, 64'h8000_0000_0000_0000, 1'b1);
		send_add(64'h1000, 64'h2000, 64'h1, 1'b0);
		send_final();
		send_data(64'h0);
		send_page(1'b1);
		send_data(64'h0);
		send_final();
		// Pause until every expected word has arrived.
		drain();
		send_create(32'h1, 64'h1);
		send_add(64'h1000, 64'h1000, 64'h7, 1'b1);
		for (int i = 0; i < 100; i++) send_data(64'h0);
		send_create(32'h2, 64'h10000);
		send_final();

		// Random part: mostly well-formed measurements with some noise.
		while (sent < 900) begin
			if ($urandom_range(0, 9) == 0) begin
				emh_pkg::in_word_t d;
				d = '0;
				d.func = 2'($urandom_range(0, 3));
				d.base = pick64();
				d.addr = pick64();
				d.page_flags = pick64();
				d.extend = 1'($urandom_range(0, 1));
				d.ssa_frame_size = $urandom();
				d.enclave_size = pick64();
				d.page_word = pick64();
				send_word(d);
			end else begin
				send_create($urandom(), pick64());
				repeat ($urandom_range(0, 4)) begin
					b = pick64();
					if ($urandom_range(0, 7) == 0) begin
						send_add(b, pick64(), pick64(), 1'b0);
					end else if ($urandom_range(0, 15) == 0) begin
						send_add(b | 64'h1, b | 64'h1 + 64'($urandom()), pick64() | 64'h1, 1'b1);
						for (int i = $urandom_range(1, 200); i > 0; i--) send_data(pick64());
					end else begin
						send_add(b | 64'h1, (b | 64'h1) + 64'($urandom()),
							pick64() | 64'h1, 1'b0);
					end
				end
				if ($urandom_range(0, 5) != 0) send_final();
			end
		end

		drain();
		repeat (300) @(posedge clk);
		if (board.errors == 0 && board.pending.size() == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

	// Watchdog against a hung handshake.
	initial begin
		#60000000;
		$display("Regression FAIL");
		$finish;
	end
endmodule
